FILE: hw/rtl/rhst_pkg.sv
`timescale 1ns / 1ps
// Package for the request handler subscription table.
// Holds field widths, request and status codes, and the controller/datapath structs.
package rhst_pkg;

    localparam int TYPE_W   = 2;
    localparam int ID_W     = 8;
    localparam int HND_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    // At most this many beats are returned by one query.
    localparam int RESULT_CAP = 8;

    localparam logic [TYPE_W-1:0] REQ_REG   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_UNREG = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ID_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

    typedef struct packed {
        logic                acc;
        logic                clr_wr;
        logic                k_clr;
        logic                k_inc;
        logic                load_k;
        logic                cnt_rd;
        logic                n_load;
        logic                i_inc;
        logic                tab_rd;
        logic                rd_next;
        logic                tab_wr_app;
        logic                tab_wr_sh;
        logic                cnt_dec;
        logic                batch_end;
        logic                out_ld;
        logic                out_list;
        logic [STATUS_W-1:0] out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic k_done;
        logic id_bad;
        logic ovf;
        logic kind;
        logic cnt_full;
        logic n_full;
        logic null_h;
        logic i_done;
        logic n_zero;
        logic hit;
        logic show_last;
        logic shift_done;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hw/rtl/rhst_dp.sv
`timescale 1ns / 1ps
// Datapath of the subscription table: count and handler memories, batch buffer,
// loop counters and the output register. Depends on rhst_pkg.
module rhst_dp #(
    parameter int NUM_REQUESTS  = 32,
    parameter int HANDLER_LIMIT = 8,
    parameter int BATCH_MAX     = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rhst_pkg::t_dp_cmd                   i_cmd,
    output rhst_pkg::t_dp_stat                  o_stat,
    input  logic [rhst_pkg::TYPE_W-1:0]         i_req_type,
    input  logic [rhst_pkg::ID_W-1:0]           i_request_id,
    input  logic [rhst_pkg::HND_W-1:0]          i_handler_id,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [rhst_pkg::STATUS_W-1:0]       o_status,
    output logic [rhst_pkg::HND_W-1:0]          o_found_handler,
    output logic [rhst_pkg::COUNT_W-1:0]        o_handler_count,
    output logic                                o_last_result
);
    import rhst_pkg::*;

    localparam int CW  = $clog2(HANDLER_LIMIT + 1);
    localparam int SW  = (CW + 1 > 5) ? CW + 1 : 5;
    localparam int CAW = (NUM_REQUESTS > 1) ? $clog2(NUM_REQUESTS) : 1;
    localparam int TD  = NUM_REQUESTS * HANDLER_LIMIT;
    localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
    localparam int LW  = $clog2(BATCH_MAX + 1);
    localparam int BW  = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;

    logic [CW-1:0]       r_cnt_mem [NUM_REQUESTS];
    logic [HND_W-1:0]    r_tab_mem [TD];
    logic [ID_W-1:0]     r_pid [BATCH_MAX];
    logic [HND_W-1:0]    r_ph [BATCH_MAX];

    logic [CAW-1:0]      r_clr;
    logic [LW-1:0]       r_plen;
    logic                r_pkind;
    logic                r_povf;
    logic [LW-1:0]       r_k;
    logic [ID_W-1:0]     r_cid;
    logic [HND_W-1:0]    r_ch;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_cnt_q;
    logic [HND_W-1:0]    r_tab_q;
    logic                r_ov;
    logic [STATUS_W-1:0] r_ostatus;
    logic [HND_W-1:0]    r_ofound;
    logic [COUNT_W-1:0]  r_ocount;
    logic                r_olast;

    logic [CAW-1:0]      w_ridx;
    logic [TAW-1:0]      w_base;
    logic [CW-1:0]       w_rd_idx;
    logic [CW-1:0]       w_wr_idx;
    logic [TAW-1:0]      w_rd_addr;
    logic [TAW-1:0]      w_wr_addr;
    logic [SW-1:0]       w_i1;
    logic [SW-1:0]       w_shown;
    logic                w_batch_acc;

    assign w_ridx    = CAW'(r_cid);
    assign w_base    = TAW'(int'(w_ridx) * HANDLER_LIMIT);
    assign w_rd_idx  = i_cmd.rd_next ? CW'(r_i + 1'b1) : r_i;
    assign w_wr_idx  = i_cmd.tab_wr_app ? r_n : r_i;
    assign w_rd_addr = w_base + TAW'(w_rd_idx);
    assign w_wr_addr = w_base + TAW'(w_wr_idx);
    assign w_i1      = SW'(r_i) + SW'(1);
    assign w_shown   = (SW'(r_n) > SW'(RESULT_CAP)) ? SW'(RESULT_CAP) : SW'(r_n);
    assign w_batch_acc = i_cmd.acc && (i_req_type == REQ_REG || i_req_type == REQ_UNREG);

    assign o_stat.clr_done   = (r_clr == CAW'(NUM_REQUESTS - 1));
    assign o_stat.k_done     = (r_k == r_plen);
    assign o_stat.id_bad     = ({1'b0, r_cid} >= 9'(NUM_REQUESTS));
    assign o_stat.ovf        = r_povf;
    assign o_stat.kind       = r_pkind;
    assign o_stat.cnt_full   = (SW'(r_cnt_q) >= SW'(HANDLER_LIMIT));
    assign o_stat.n_full     = (SW'(r_n) >= SW'(HANDLER_LIMIT));
    assign o_stat.null_h     = (r_ch == '0);
    assign o_stat.i_done     = (r_i == r_n);
    assign o_stat.n_zero     = (r_n == '0);
    assign o_stat.hit        = (r_tab_q == r_ch);
    assign o_stat.show_last  = (w_i1 == w_shown);
    assign o_stat.shift_done = (w_i1 >= SW'(r_n));
    assign o_stat.out_free   = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_cnt_mem[r_clr] <= '0;
        end else if (i_cmd.tab_wr_app) begin
            r_cnt_mem[w_ridx] <= CW'(r_n + 1'b1);
        end else if (i_cmd.cnt_dec) begin
            r_cnt_mem[w_ridx] <= CW'(r_n - 1'b1);
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= r_cnt_mem[w_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_wr_app) begin
            r_tab_mem[w_wr_addr] <= r_ch;
        end else if (i_cmd.tab_wr_sh) begin
            r_tab_mem[w_wr_addr] <= r_tab_q;
        end
        if (i_cmd.tab_rd) begin
            r_tab_q <= r_tab_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_batch_acc && (LW'(BATCH_MAX) > r_plen)) begin
            r_pid[r_plen[BW-1:0]] <= i_request_id;
            r_ph[r_plen[BW-1:0]]  <= i_handler_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_plen  <= '0;
            r_pkind <= 1'b0;
            r_povf  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= CAW'(r_clr + 1'b1);
            end
            if (w_batch_acc) begin
                if (r_plen == '0 && !r_povf) begin
                    r_pkind <= (i_req_type == REQ_UNREG);
                end
                if (LW'(BATCH_MAX) > r_plen) begin
                    r_plen <= LW'(r_plen + 1'b1);
                end else begin
                    r_povf <= 1'b1;
                end
            end else if (i_cmd.batch_end) begin
                r_plen <= '0;
                r_povf <= 1'b0;
            end
            if (i_cmd.out_ld) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_cid <= i_request_id;
            r_ch  <= i_handler_id;
        end else if (i_cmd.load_k) begin
            r_cid <= r_pid[r_k[BW-1:0]];
            r_ch  <= r_ph[r_k[BW-1:0]];
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= LW'(r_k + 1'b1);
        end
        if (i_cmd.n_load) begin
            r_n <= r_cnt_q;
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= CW'(r_i + 1'b1);
        end
        if (i_cmd.out_ld) begin
            if (i_cmd.out_list) begin
                r_ostatus <= ST_OK;
                r_ofound  <= r_tab_q;
                r_ocount  <= COUNT_W'(r_n);
                r_olast   <= o_stat.show_last;
            end else begin
                r_ostatus <= i_cmd.out_status;
                r_ofound  <= '0;
                r_ocount  <= '0;
                r_olast   <= 1'b1;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_status        = r_ostatus;
    assign o_found_handler = r_ofound;
    assign o_handler_count = r_ocount;
    assign o_last_result   = r_olast;

endmodule

FILE: hw/rtl/rhst_ctrl.sv
`timescale 1ns / 1ps
// Controller of the subscription table: sequences clearing, batch checks,
// appends, removals and queries. Depends on rhst_pkg.
module rhst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [rhst_pkg::TYPE_W-1:0] i_req_type,
    input  logic                        i_last_in_batch,
    output logic                        o_ready,
    output rhst_pkg::t_dp_cmd           o_cmd,
    input  rhst_pkg::t_dp_stat          i_stat
);
    import rhst_pkg::*;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_QCHK   = 5'd2;
    localparam logic [4:0] S_QCNT   = 5'd3;
    localparam logic [4:0] S_QRD    = 5'd4;
    localparam logic [4:0] S_QEMIT  = 5'd5;
    localparam logic [4:0] S_QBAD   = 5'd6;
    localparam logic [4:0] S_BSTART = 5'd7;
    localparam logic [4:0] S_RVLD   = 5'd8;
    localparam logic [4:0] S_RV1    = 5'd9;
    localparam logic [4:0] S_RV2    = 5'd10;
    localparam logic [4:0] S_RAPP   = 5'd11;
    localparam logic [4:0] S_RA1    = 5'd12;
    localparam logic [4:0] S_RA2    = 5'd13;
    localparam logic [4:0] S_RSCAN  = 5'd14;
    localparam logic [4:0] S_RCMP   = 5'd15;
    localparam logic [4:0] S_UVLD   = 5'd16;
    localparam logic [4:0] S_UV1    = 5'd17;
    localparam logic [4:0] S_UAPP   = 5'd18;
    localparam logic [4:0] S_UA1    = 5'd19;
    localparam logic [4:0] S_UA2    = 5'd20;
    localparam logic [4:0] S_USCAN  = 5'd21;
    localparam logic [4:0] S_UCMP   = 5'd22;
    localparam logic [4:0] S_USH    = 5'd23;
    localparam logic [4:0] S_USW    = 5'd24;
    localparam logic [4:0] S_BDONE  = 5'd25;

    logic [4:0]          r_state;
    logic [4:0]          n_state;
    logic [STATUS_W-1:0] r_code;
    logic [STATUS_W-1:0] n_code;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    unique case (i_req_type) inside
                        REQ_QUERY: n_state = S_QCHK;
                        REQ_REG, REQ_UNREG: begin
                            if (i_last_in_batch) begin
                                n_state = S_BSTART;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_QCHK: begin
                if (i_stat.id_bad) begin
                    n_state = S_QBAD;
                end else begin
                    o_cmd.cnt_rd = 1'b1;
                    n_state = S_QCNT;
                end
            end
            S_QCNT: begin
                o_cmd.n_load = 1'b1;
                n_state = S_QRD;
            end
            S_QRD: begin
                if (i_stat.n_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_ld = 1'b1;
                        o_cmd.out_status = ST_OK;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.tab_rd = 1'b1;
                    n_state = S_QEMIT;
                end
            end
            S_QEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.out_list = 1'b1;
                    if (i_stat.show_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state = S_QRD;
                    end
                end
            end
            S_QBAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.out_status = ST_ID_INVALID;
                    n_state = S_IDLE;
                end
            end
            S_BSTART: begin
                o_cmd.k_clr = 1'b1;
                if (i_stat.ovf) begin
                    n_code = ST_TOO_LONG;
                    n_state = S_BDONE;
                end else if (i_stat.kind) begin
                    n_state = S_UVLD;
                end else begin
                    n_state = S_RVLD;
                end
            end
            S_RVLD: begin
                if (i_stat.k_done) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_RAPP;
                end else begin
                    o_cmd.load_k = 1'b1;
                    n_state = S_RV1;
                end
            end
            S_RV1: begin
                if (i_stat.id_bad) begin
                    n_code = ST_ID_INVALID;
                    n_state = S_BDONE;
                end else begin
                    o_cmd.cnt_rd = 1'b1;
                    n_state = S_RV2;
                end
            end
            S_RV2: begin
                if (i_stat.cnt_full) begin
                    n_code = ST_LIMIT;
                    n_state = S_BDONE;
                end else if (i_stat.null_h) begin
                    n_code = ST_NULL;
                    n_state = S_BDONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_RVLD;
                end
            end
            S_RAPP: begin
                if (i_stat.k_done) begin
                    n_code = ST_OK;
                    n_state = S_BDONE;
                end else begin
                    o_cmd.load_k = 1'b1;
                    n_state = S_RA1;
                end
            end
            S_RA1: begin
                o_cmd.cnt_rd = 1'b1;
                n_state = S_RA2;
            end
            S_RA2: begin
                o_cmd.n_load = 1'b1;
                n_state = S_RSCAN;
            end
            S_RSCAN: begin
                if (i_stat.i_done) begin
                    o_cmd.tab_wr_app = !i_stat.n_full;
                    o_cmd.k_inc = 1'b1;
                    n_state = S_RAPP;
                end else begin
                    o_cmd.tab_rd = 1'b1;
                    n_state = S_RCMP;
                end
            end
            S_RCMP: begin
                if (i_stat.hit) begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_RAPP;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state = S_RSCAN;
                end
            end
            S_UVLD: begin
                if (i_stat.k_done) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_UAPP;
                end else begin
                    o_cmd.load_k = 1'b1;
                    n_state = S_UV1;
                end
            end
            S_UV1: begin
                if (i_stat.id_bad) begin
                    n_code = ST_ID_INVALID;
                    n_state = S_BDONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_UVLD;
                end
            end
            S_UAPP: begin
                if (i_stat.k_done) begin
                    n_code = ST_OK;
                    n_state = S_BDONE;
                end else begin
                    o_cmd.load_k = 1'b1;
                    n_state = S_UA1;
                end
            end
            S_UA1: begin
                o_cmd.cnt_rd = 1'b1;
                n_state = S_UA2;
            end
            S_UA2: begin
                o_cmd.n_load = 1'b1;
                n_state = S_USCAN;
            end
            S_USCAN: begin
                if (i_stat.i_done) begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_UAPP;
                end else begin
                    o_cmd.tab_rd = 1'b1;
                    n_state = S_UCMP;
                end
            end
            S_UCMP: begin
                if (i_stat.hit) begin
                    n_state = S_USH;
                end else begin
                    o_cmd.i_inc = 1'b1;
                    n_state = S_USCAN;
                end
            end
            S_USH: begin
                if (i_stat.shift_done) begin
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.k_inc = 1'b1;
                    n_state = S_UAPP;
                end else begin
                    o_cmd.tab_rd = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state = S_USW;
                end
            end
            S_USW: begin
                o_cmd.tab_wr_sh = 1'b1;
                o_cmd.i_inc = 1'b1;
                n_state = S_USH;
            end
            S_BDONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.out_status = r_code;
                    o_cmd.batch_end = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    a_app_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tab_wr_app |-> !i_stat.n_full)
        else $error("Append issued to a full list.");

    a_cnt_valid_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_rd |-> !i_stat.id_bad)
        else $error("Count read with an out of range id.");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_stat.out_free)
        else $error("Result beat loaded over an untaken beat.");

endmodule

FILE: hw/rtl/request_handler_subscription_table_top.sv
`timescale 1ns / 1ps
// Top level of the request handler subscription table.
// Instantiates rhst_ctrl and rhst_dp; depends on rhst_pkg.
//
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_ready    req_type, request_id, handler_id, last_in_batch
// result   out        o_valid / i_ready    status, found_handler, handler_count, last_result
//
// After reset the count memory is cleared entry by entry before the first beat is taken.
// Batch beats are buffered on acceptance; the last one starts the batch. A query checks
// the id, reads the count, then reads and emits each listed handler in turn. A register
// batch checks every item, then scans each list and appends absent handlers; unregister
// shifts later entries down over a hit. A full output register stalls the sequencer.
module request_handler_subscription_table_top #(
    parameter int NUM_REQUESTS  = 32,
    parameter int HANDLER_LIMIT = 8,
    parameter int BATCH_MAX     = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rhst_pkg::TYPE_W-1:0]  i_req_type,
    input  logic [rhst_pkg::ID_W-1:0]    i_request_id,
    input  logic [rhst_pkg::HND_W-1:0]   i_handler_id,
    input  logic                         i_last_in_batch,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rhst_pkg::STATUS_W-1:0] o_status,
    output logic [rhst_pkg::HND_W-1:0]   o_found_handler,
    output logic [rhst_pkg::COUNT_W-1:0] o_handler_count,
    output logic                         o_last_result
);
    import rhst_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rhst_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_req_type      (i_req_type),
        .i_last_in_batch (i_last_in_batch),
        .o_ready         (o_ready),
        .o_cmd           (w_cmd),
        .i_stat          (w_stat)
    );

    rhst_dp #(
        .NUM_REQUESTS  (NUM_REQUESTS),
        .HANDLER_LIMIT (HANDLER_LIMIT),
        .BATCH_MAX     (BATCH_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_req_type      (i_req_type),
        .i_request_id    (i_request_id),
        .i_handler_id    (i_handler_id),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_found_handler (o_found_handler),
        .o_handler_count (o_handler_count),
        .o_last_result   (o_last_result)
    );

endmodule

FILE: dv/rhst_checker.sv
`timescale 1ns / 1ps
// Checker for the request handler subscription table: keeps its own copy of the
// table and the pending batch, predicts result beats and compares them. Uses rhst_pkg.
module rhst_checker #(
    parameter int NUM_REQUESTS  = 32,
    parameter int HANDLER_LIMIT = 8,
    parameter int BATCH_MAX     = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [rhst_pkg::TYPE_W-1:0]   i_req_type,
    input  logic [rhst_pkg::ID_W-1:0]     i_request_id,
    input  logic [rhst_pkg::HND_W-1:0]    i_handler_id,
    input  logic                          i_last_in_batch,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [rhst_pkg::STATUS_W-1:0] o_status,
    input  logic [rhst_pkg::HND_W-1:0]    o_found_handler,
    input  logic [rhst_pkg::COUNT_W-1:0]  o_handler_count,
    input  logic                          o_last_result,
    output int                            o_fail_count,
    output int                            o_pending_beats,
    output int                            o_result_beats
);
    import rhst_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HND_W-1:0]    handler;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_beat;

    logic [HND_W-1:0] lists [NUM_REQUESTS][HANDLER_LIMIT];
    int               counts [NUM_REQUESTS];
    logic [ID_W-1:0]  batch_ids [BATCH_MAX];
    logic [HND_W-1:0] batch_hnds [BATCH_MAX];
    int               batch_len;
    logic [TYPE_W-1:0] batch_kind;
    bit               batch_ovf;
    t_beat            expected_beats [$];

    function automatic t_beat mk(logic [STATUS_W-1:0] s, logic [HND_W-1:0] h, int c, bit l);
        t_beat b;
        b.status = s;
        b.handler = h;
        b.count = c[COUNT_W-1:0];
        b.last = l;
        return b;
    endfunction

    function automatic logic [STATUS_W-1:0] apply_register();
        int id;
        int n;
        bit dup;
        for (int k = 0; k < batch_len; k++) begin
            id = batch_ids[k];
            if (id >= NUM_REQUESTS) return ST_ID_INVALID;
            if (counts[id] >= HANDLER_LIMIT) return ST_LIMIT;
            if (batch_hnds[k] == '0) return ST_NULL;
        end
        for (int k = 0; k < batch_len; k++) begin
            id = batch_ids[k];
            n = counts[id];
            dup = 0;
            for (int i = 0; i < n; i++) if (lists[id][i] == batch_hnds[k]) dup = 1;
            if (!dup && n < HANDLER_LIMIT) begin
                lists[id][n] = batch_hnds[k];
                counts[id] = n + 1;
            end
        end
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] apply_unregister();
        int id;
        int n;
        bit done;
        for (int k = 0; k < batch_len; k++)
            if (batch_ids[k] >= NUM_REQUESTS) return ST_ID_INVALID;
        for (int k = 0; k < batch_len; k++) begin
            id = batch_ids[k];
            n = counts[id];
            done = 0;
            for (int i = 0; i < n; i++) begin
                if (!done && lists[id][i] == batch_hnds[k]) begin
                    for (int j = i; j + 1 < n; j++) lists[id][j] = lists[id][j+1];
                    lists[id][n-1] = '0;
                    counts[id] = n - 1;
                    done = 1;
                end
            end
        end
        return ST_OK;
    endfunction

    task automatic predict_beat(logic [TYPE_W-1:0] t, logic [ID_W-1:0] id,
                                logic [HND_W-1:0] h, logic l);
        int n;
        int shown;
        logic [STATUS_W-1:0] st;
        if (t == REQ_QUERY) begin
            if (id >= NUM_REQUESTS) expected_beats.push_back(mk(ST_ID_INVALID, '0, 0, 1));
            else if (counts[id] == 0) expected_beats.push_back(mk(ST_OK, '0, 0, 1));
            else begin
                n = counts[id];
                shown = n < RESULT_CAP ? n : RESULT_CAP;
                for (int i = 0; i < shown; i++)
                    expected_beats.push_back(mk(ST_OK, lists[id][i], n, i + 1 == shown));
            end
        end else if (t == REQ_REG || t == REQ_UNREG) begin
            if (batch_len == 0 && !batch_ovf) batch_kind = t;
            if (batch_len < BATCH_MAX) begin
                batch_ids[batch_len] = id;
                batch_hnds[batch_len] = h;
                batch_len++;
            end else batch_ovf = 1;
            if (l) begin
                if (batch_ovf) st = ST_TOO_LONG;
                else if (batch_kind == REQ_REG) st = apply_register();
                else st = apply_unregister();
                batch_len = 0;
                batch_ovf = 0;
                expected_beats.push_back(mk(st, '0, 0, 1));
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_result_beats = 0;
        o_pending_beats = 0;
        batch_len = 0;
        batch_ovf = 0;
        batch_kind = REQ_REG;
        for (int r = 0; r < NUM_REQUESTS; r++) begin
            counts[r] = 0;
            for (int i = 0; i < HANDLER_LIMIT; i++) lists[r][i] = '0;
        end
    end

    always @(posedge i_clk) begin
        t_beat e;
        int errs;
        errs = 0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                o_result_beats <= o_result_beats + 1;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    e = expected_beats.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        errs++;
                    end
                    if (o_found_handler !== e.handler) begin
                        $error("found_handler exp %0h got %0h", e.handler, o_found_handler);
                        errs++;
                    end
                    if (o_handler_count !== e.count) begin
                        $error("handler_count exp %0d got %0d", e.count, o_handler_count);
                        errs++;
                    end
                    if (o_last_result !== e.last) begin
                        $error("last_result exp %0d got %0d", e.last, o_last_result);
                        errs++;
                    end
                end
            end
            if (i_valid && o_ready)
                predict_beat(i_req_type, i_request_id, i_handler_id, i_last_in_batch);
            if (errs != 0)
                o_fail_count <= o_fail_count + errs;
            o_pending_beats <= expected_beats.size();
        end
    end
endmodule

FILE: dv/request_handler_subscription_table_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for request_handler_subscription_table_top: drives directed and random
// beats with random idling and gives the verdict. Depends on rhst_pkg and rhst_checker.
module request_handler_subscription_table_top_tb;
    import rhst_pkg::*;

    localparam int NREQ = 32;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic [TYPE_W-1:0] i_req_type = '0;
    logic [ID_W-1:0] i_request_id = '0;
    logic [HND_W-1:0] i_handler_id = '0;
    logic i_last_in_batch = 0;
    logic o_valid;
    logic i_ready = 0;
    logic [STATUS_W-1:0] o_status;
    logic [HND_W-1:0] o_found_handler;
    logic [COUNT_W-1:0] o_handler_count;
    logic o_last_result;
    int fail_count, pending_beats, result_beats;
    int cycles = 0;
    int send_idle = 22, recv_idle = 82;
    bit hold_recv = 0;
    int items_sent = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    request_handler_subscription_table_top dut (.*);

    rhst_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req_type, .i_request_id,
        .i_handler_id, .i_last_in_batch, .o_valid, .i_ready, .o_status,
        .o_found_handler, .o_handler_count, .o_last_result,
        .o_fail_count(fail_count), .o_pending_beats(pending_beats),
        .o_result_beats(result_beats)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL request_handler_subscription_table_top");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);

    task automatic send_beat(logic [TYPE_W-1:0] t, logic [ID_W-1:0] id,
                             logic [HND_W-1:0] h, logic l);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= t;
        i_request_id <= id;
        i_handler_id <= h;
        i_last_in_batch <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r = $urandom_range(99);
        if (r < 85) return ID_W'($urandom_range(7));
        if (r < 93) return ID_W'($urandom_range(NREQ - 1));
        return ID_W'($urandom_range(255, NREQ));
    endfunction

    function automatic logic [HND_W-1:0] pick_hnd();
        int r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 75) return HND_W'($urandom_range(12, 1));
        return HND_W'($urandom_range(16'hFFFF));
    endfunction

    task automatic random_phase(int n);
        int len;
        logic [TYPE_W-1:0] k;
        for (int b = 0; b < n; b++) begin
            case ($urandom_range(9))
                0, 1, 2: send_beat(REQ_QUERY, pick_id(), HND_W'($urandom),
                                   1'($urandom_range(1)));
                3: send_beat(REQ_UNUSED, ID_W'($urandom), HND_W'($urandom),
                             1'($urandom_range(1)));
                default: begin
                    len = ($urandom_range(19) == 0) ? $urandom_range(11, 9) : $urandom_range(4, 1);
                    k = ($urandom_range(2) == 0) ? REQ_UNREG : REQ_REG;
                    for (int i = 0; i < len; i++)
                        send_beat(($urandom_range(9) == 0) ? ~k & 2'b01 : k,
                                  pick_id(), pick_hnd(), i == len - 1);
                end
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // Directed: empty and invalid queries, fill a list, overflow it, duplicates.
        send_beat(REQ_QUERY, 0, 0, 0);
        send_beat(REQ_QUERY, 8'hFF, 16'hFFFF, 1);
        send_beat(REQ_UNUSED, 0, 1, 1);
        for (int i = 0; i < 8; i++) send_beat(REQ_REG, 1, HND_W'(16'hFFF0 + i), i == 7);
        send_beat(REQ_QUERY, 1, 0, 0);
        send_beat(REQ_REG, 1, 16'h5555, 1);
        send_beat(REQ_REG, 2, 16'hAAAA, 0);
        send_beat(REQ_REG, 2, 16'hAAAA, 0);
        send_beat(REQ_REG, 2, 0, 1);
        send_beat(REQ_REG, NREQ, 16'h1, 1);
        send_beat(REQ_UNREG, 1, 16'hFFF3, 0);
        send_beat(REQ_REG, 1, 16'h0, 1);
        send_beat(REQ_QUERY, 1, 0, 0);
        for (int i = 0; i < 9; i++) send_beat(REQ_UNREG, 1, HND_W'(16'hFFF0 + i), i == 8);
        send_beat(REQ_UNREG, 8'hFF, 16'hFFF0, 1);
        send_beat(REQ_UNREG, 1, 16'hFFF7, 1);
        send_beat(REQ_QUERY, 1, 0, 1);
        random_phase(42);
        // Hold the receiver off so the output fills and the input stalls.
        hold_recv = 1;
        fork
            begin
                for (int c = 0; c < 300; c++) @(posedge i_clk);
                hold_recv = 0;
            end
            random_phase(12);
        join
        send_idle = 82;
        recv_idle = 22;
        random_phase(42);
        send_idle = 0;
        recv_idle = 0;
        random_phase(42);
        i_valid <= 0;
        repeat (2) @(posedge i_clk);
        while (pending_beats != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d input beats, checked %0d result beats", items_sent, result_beats);
        $display("over register, unregister, query and ignored beats with stalls.");
        if (fail_count == 0 && pending_beats == 0)
            $display("PASS request_handler_subscription_table_top");
        else
            $display("FAIL request_handler_subscription_table_top");
        $finish;
    end
endmodule

FILE: files.f
hw/rtl/rhst_pkg.sv
hw/rtl/rhst_dp.sv
hw/rtl/rhst_ctrl.sv
hw/rtl/request_handler_subscription_table_top.sv
dv/rhst_checker.sv
dv/request_handler_subscription_table_top_tb.sv
